FILE: rtl/lzwd_pkg.sv
// Shared types, constants and the control store of the LZSS window decoder.
`default_nettype none

package lzwd_pkg;

	localparam int DEF_POS_BITS     = 13;
	localparam int DEF_LEN_BITS     = 4;
	localparam int DEF_WINDOW_DEPTH = 8192;
	localparam int MIN_MATCH        = 3;
	localparam int LIT_TOKEN_BITS   = 9;

	typedef enum logic [3:0] {
		ST_FETCH     = 4'd0,
		ST_SHIFT     = 4'd1,
		ST_DISP_LIT  = 4'd2,
		ST_DISP_EOS  = 4'd3,
		ST_DISP_MAT  = 4'd4,
		ST_RESUME    = 4'd5,
		ST_BACK      = 4'd6,
		ST_LIT       = 4'd7,
		ST_EOS       = 4'd8,
		ST_REDUCE    = 4'd9,
		ST_MATCH_RD  = 4'd10,
		ST_MATCH_CPY = 4'd11,
		ST_MATCH_END = 4'd12
	} step_t;

	typedef enum logic [3:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_MORE_BITS,
		COND_TOK_LIT,
		COND_TOK_EOS,
		COND_TOK_MAT,
		COND_BITS_LEFT,
		COND_COPY_LEFT,
		COND_PTR_HIGH
	} cond_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_LIT,
		EMIT_EOS,
		EMIT_COPY
	} emit_t;

	typedef enum logic [1:0] {
		TOK_NONE,
		TOK_LIT,
		TOK_EOS,
		TOK_MAT
	} tok_t;

	typedef struct packed {
		logic  wait_in;
		logic  wait_out;
		logic  shift;
		logic  rd_en;
		logic  reduce;
		emit_t emit;
		cond_t cond;
		step_t target;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic more_bits;
		logic bits_left;
		logic tok_lit;
		logic tok_eos;
		logic tok_mat;
		logic copy_left;
		logic ptr_high;
	} flags_t;

	// Control store: one word per step, falls through to the next step
	// unless the condition holds.
	function automatic ctl_t ucode(input step_t s);
		ctl_t c;
		begin
			c = '0;
			c.emit = EMIT_NONE;
			c.cond = COND_NEVER;
			c.target = ST_FETCH;
			case (s)
				ST_FETCH: begin
					c.wait_in = 1'b1;
				end
				ST_SHIFT: begin
					c.shift = 1'b1;
					c.cond = COND_MORE_BITS;
					c.target = ST_SHIFT;
				end
				ST_DISP_LIT: begin
					c.cond = COND_TOK_LIT;
					c.target = ST_LIT;
				end
				ST_DISP_EOS: begin
					c.cond = COND_TOK_EOS;
					c.target = ST_EOS;
				end
				ST_DISP_MAT: begin
					c.cond = COND_TOK_MAT;
					c.target = ST_REDUCE;
				end
				ST_RESUME: begin
					c.cond = COND_BITS_LEFT;
					c.target = ST_SHIFT;
				end
				ST_BACK: begin
					c.cond = COND_ALWAYS;
					c.target = ST_FETCH;
				end
				ST_LIT: begin
					c.wait_out = 1'b1;
					c.emit = EMIT_LIT;
					c.cond = COND_ALWAYS;
					c.target = ST_RESUME;
				end
				ST_EOS: begin
					c.wait_out = 1'b1;
					c.emit = EMIT_EOS;
					c.cond = COND_ALWAYS;
					c.target = ST_FETCH;
				end
				ST_REDUCE: begin
					c.reduce = 1'b1;
					c.cond = COND_PTR_HIGH;
					c.target = ST_REDUCE;
				end
				ST_MATCH_RD: begin
					c.rd_en = 1'b1;
				end
				ST_MATCH_CPY: begin
					c.wait_out = 1'b1;
					c.emit = EMIT_COPY;
					c.cond = COND_COPY_LEFT;
					c.target = ST_MATCH_RD;
				end
				ST_MATCH_END: begin
					c.cond = COND_ALWAYS;
					c.target = ST_RESUME;
				end
				default: begin
					c.cond = COND_ALWAYS;
					c.target = ST_FETCH;
				end
			endcase
			return c;
		end
	endfunction

endpackage

`default_nettype wire

FILE: rtl/lzwd_in_if.sv
// Compressed input channel: valid/ready handshake with one packed byte.
`default_nettype none

interface lzwd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] packed_byte;

	modport source(output valid, output packed_byte, input ready);
	modport sink(input valid, input packed_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/lzwd_out_if.sv
// Decoded output channel: valid/ready handshake with one plain byte and flags.
`default_nettype none

interface lzwd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] plain_byte;
	logic       run_last;
	logic       stream_end;

	modport source(output valid, output plain_byte, output run_last, output stream_end,
		input ready);
	modport sink(input valid, input plain_byte, input run_last, input stream_end,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/lzwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lzwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lzwd_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none

module lzwd_seq import lzwd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire flags_t flags,
	output ctl_t        ctl,
	output logic        fire
);

	step_t step_q;
	step_t step_nx;
	logic  taken;

	always_comb begin
		ctl = ucode(step_q);
	end

	// Hold the step while waiting on either channel.
	always_comb begin
		fire = !((ctl.wait_in && !flags.in_valid) || (ctl.wait_out && !flags.out_free));
	end

	always_comb begin
		case (ctl.cond)
			COND_NEVER:     taken = 1'b0;
			COND_ALWAYS:    taken = 1'b1;
			COND_MORE_BITS: taken = flags.more_bits;
			COND_TOK_LIT:   taken = flags.tok_lit;
			COND_TOK_EOS:   taken = flags.tok_eos;
			COND_TOK_MAT:   taken = flags.tok_mat;
			COND_BITS_LEFT: taken = flags.bits_left;
			COND_COPY_LEFT: taken = flags.copy_left;
			COND_PTR_HIGH:  taken = flags.ptr_high;
			default:        taken = 1'b1;
		endcase
	end

	always_comb begin
		if (!fire) begin
			step_nx = step_q;
		end else if (taken) begin
			step_nx = ctl.target;
		end else begin
			step_nx = step_t'(step_q + 4'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_FETCH;
		end else begin
			step_q <= step_nx;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lzss_window_decoder.sv
// LZSS window decoder top level: bit reader, copy datapath and history window.
//
// Each compressed byte is read one bit per cycle, MSB first, under a microcoded
// sequencer; the reading pauses while the next byte is fetched and while a
// token is handled. Each copied byte of a match is one registered read of the
// history RAM followed by its write and emit. A match position at or above the
// window depth is first reduced by subtracting the depth until it lies below.
// Results leave through an output register, so the decoder keeps working while
// a result waits, up to its next result. The history RAM has no reset; after
// reset the block is ready at once, and history entries read before they are
// written return anything.
`default_nettype none

module lzss_window_decoder import lzwd_pkg::*; #(
	parameter int POS_BITS     = DEF_POS_BITS,
	parameter int LEN_BITS     = DEF_LEN_BITS,
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	lzwd_in_if.sink     compressed,
	lzwd_out_if.source  decoded
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int PW = (POS_BITS > AW) ? POS_BITS : AW;
	localparam int TW = POS_BITS + LEN_BITS;
	localparam int HW = $clog2(TW + 2);
	localparam int RW = LEN_BITS + 1;

	ctl_t   ctl;
	logic   fire;
	flags_t flags;

	logic [7:0]    byte_q;
	logic [2:0]    bit_cnt_q;
	logic          flag_q;
	logic [TW-1:0] pay_q;
	logic [HW-1:0] held_q;
	tok_t          tok_q;
	logic [7:0]    lit_q;
	logic [PW-1:0] ptr_q;
	logic [RW-1:0] remain_q;
	logic [AW-1:0] wpos_q;

	logic       out_valid_q;
	logic [7:0] plain_q;
	logic       run_last_q;
	logic       stream_end_q;

	logic          bit_in;
	logic [HW-1:0] held_nx;
	logic [TW-1:0] pay_nx;
	tok_t          detect;
	logic          out_free;
	logic          ptr_high;
	logic          emit_go;
	logic          ram_we;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [7:0]    ram_rdata;

	lzwd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl),
		.fire   (fire)
	);

	lzwd_ram #(
		.WIDTH (8),
		.DEPTH (WINDOW_DEPTH)
	) u_history (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wpos_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ptr_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Bit reader: the flag is kept apart, the payload keeps the newest bits.
	always_comb begin
		bit_in = byte_q[7];
		held_nx = held_q + HW'(1);
		pay_nx = {pay_q[TW-2:0], bit_in};
		detect = TOK_NONE;
		if (held_q != '0) begin
			if (flag_q) begin
				if (held_nx == HW'(LIT_TOKEN_BITS)) begin
					detect = TOK_LIT;
				end
			end else if (held_nx == HW'(1 + POS_BITS)) begin
				if (pay_nx[POS_BITS-1:0] == '0) begin
					detect = TOK_EOS;
				end
			end else if (held_nx == HW'(1 + TW)) begin
				detect = TOK_MAT;
			end
		end
	end

	always_comb begin
		out_free = !out_valid_q || decoded.ready;
		ptr_high = ({1'b0, ptr_q} >= (PW + 1)'(WINDOW_DEPTH));
		emit_go = fire && (ctl.emit != EMIT_NONE);
	end

	always_comb begin
		flags.in_valid = compressed.valid;
		flags.out_free = out_free;
		flags.more_bits = (bit_cnt_q != 3'd7) && (detect == TOK_NONE);
		flags.bits_left = (bit_cnt_q != 3'd0);
		flags.tok_lit = (tok_q == TOK_LIT);
		flags.tok_eos = (tok_q == TOK_EOS);
		flags.tok_mat = (tok_q == TOK_MAT);
		flags.copy_left = (remain_q != RW'(1));
		flags.ptr_high = ptr_high;
	end

	always_comb begin
		ram_we = fire && ((ctl.emit == EMIT_LIT) || (ctl.emit == EMIT_COPY));
		ram_wdata = (ctl.emit == EMIT_LIT) ? lit_q : ram_rdata;
		ram_re = fire && ctl.rd_en;
	end

	assign compressed.ready = ctl.wait_in;
	assign decoded.valid = out_valid_q;
	assign decoded.plain_byte = plain_q;
	assign decoded.run_last = run_last_q;
	assign decoded.stream_end = stream_end_q;

	// Input byte and bit reader.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			flag_q <= 1'b0;
			held_q <= '0;
			tok_q <= TOK_NONE;
		end else if (fire && ctl.wait_in) begin
			bit_cnt_q <= '0;
		end else if (fire && ctl.shift) begin
			bit_cnt_q <= bit_cnt_q + 3'd1;
			if (held_q == '0) begin
				flag_q <= bit_in;
			end
			held_q <= (detect == TOK_NONE) ? held_nx : '0;
			tok_q <= detect;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && ctl.wait_in) begin
			byte_q <= compressed.packed_byte;
		end else if (fire && ctl.shift) begin
			byte_q <= {byte_q[6:0], 1'b0};
			pay_q <= pay_nx;
			lit_q <= pay_nx[7:0];
		end
	end

	// Match pointer and byte count.
	always_ff @(posedge clk) begin
		if (fire && ctl.shift && (detect == TOK_MAT)) begin
			ptr_q <= PW'(pay_nx[TW-1:LEN_BITS]);
			remain_q <= RW'(pay_nx[LEN_BITS-1:0]) + RW'(MIN_MATCH);
		end else if (fire && ctl.reduce && ptr_high) begin
			ptr_q <= ptr_q - PW'(WINDOW_DEPTH);
		end else if (fire && (ctl.emit == EMIT_COPY)) begin
			ptr_q <= (ptr_q == PW'(WINDOW_DEPTH - 1)) ? '0 : ptr_q + PW'(1);
			remain_q <= remain_q - RW'(1);
		end
	end

	// Write position: advance on every stored byte, restart on end of stream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= AW'(1);
		end else if (fire && (ctl.emit == EMIT_EOS)) begin
			wpos_q <= AW'(1);
		end else if (ram_we) begin
			wpos_q <= (wpos_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wpos_q + AW'(1);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (decoded.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			case (ctl.emit)
				EMIT_LIT: begin
					plain_q <= lit_q;
					run_last_q <= 1'b1;
					stream_end_q <= 1'b0;
				end
				EMIT_EOS: begin
					plain_q <= '0;
					run_last_q <= 1'b1;
					stream_end_q <= 1'b1;
				end
				EMIT_COPY: begin
					plain_q <= ram_rdata;
					run_last_q <= (remain_q == RW'(1));
					stream_end_q <= 1'b0;
				end
				default: begin
					plain_q <= '0;
					run_last_q <= 1'b0;
					stream_end_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
